FILE: rtl/lirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_pkg: shared types and constants of the line inlier run segmenter
// Widths, thresholds, register indexes, phase codes and the result structs
// passed between the residual pipe, the run tracker and the result queue.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int SEG_W      = 10;

  localparam logic [PT_W-1:0] PT_LAST = PT_W'(MAX_POINTS - 1);

  // merge rule thresholds: spread in Q23.8, lengths and gap in points
  localparam int SPREAD_TIGHT = 128;
  localparam int SPREAD_LOOSE = 256;
  localparam int MIN_LEN      = 4;
  localparam int MAX_GAP      = 2;

  localparam int                   CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIM  = 2'd2;
  localparam logic [30:0]          NEAR_LIM_RST  = 31'd768;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_RUN    = 2'd1,
    PH_FRESH  = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [31:0] u;
    logic               fin;
  } resid_t;

  typedef struct packed {
    logic             seg_valid;
    logic [SEG_W-1:0] seg_index;
    logic [SEG_W-1:0] seg_start;
    logic [SEG_W-1:0] seg_end;
    logic             seg_last;
  } seg_t;

  // up to two results per point: a displaced held segment, then the end result
  typedef struct packed {
    logic v0;
    seg_t s0;
    logic v1;
    seg_t s1;
  } push_t;

  function automatic logic [SEG_W-1:0] to_seg_idx(input logic [PT_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[SEG_W-1:0];
  endfunction

endpackage

FILE: rtl/lirs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_if: point and segment channels
// Valid/ready channels; a transfer happens on a rising edge with both high.
// ----------------------------------------------------------------------------
interface lirs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface lirs_out_if;
  logic       valid;
  logic       ready;
  logic       seg_valid;
  logic [9:0] seg_index;
  logic [9:0] seg_start;
  logic [9:0] seg_end;
  logic       seg_last;

  modport source (output valid, seg_valid, seg_index, seg_start, seg_end, seg_last,
                  input ready);
  modport sink   (input valid, seg_valid, seg_index, seg_start, seg_end, seg_last,
                  output ready);
endinterface

FILE: rtl/lirs_resid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_resid: residual pipe
// Three stages: input register, registered slope product, registered
// saturated residual u = ((a * x) >>> 16) + b - y.
// ----------------------------------------------------------------------------
module lirs_resid (
  input  logic               clk,
  input  logic               rst_n,
  lirs_in_if.sink            in_ch,
  input  logic signed [31:0] slope_a,
  input  logic signed [31:0] offset_b,
  input  logic               take,
  output logic               res_valid,
  output lirs_pkg::resid_t   res
);

  logic               s1_v_r, s2_v_r, s3_v_r;
  logic               ld1, ld2, ld3;
  logic signed [31:0] s1_x_r, s1_y_r, s2_y_r;
  logic               s1_fin_r, s2_fin_r;
  logic signed [63:0] prod, s2_prod_r;
  logic signed [47:0] quo;
  logic signed [49:0] sum;
  logic signed [31:0] u_sat;
  lirs_pkg::resid_t   s3_r;

  // a stage loads when empty or when its content moves on
  assign ld3 = !s3_v_r || take;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;
  assign in_ch.ready = ld1;

  assign prod = s1_x_r * slope_a;
  assign quo  = s2_prod_r[63:16];
  assign sum  = 50'(quo) + 50'(offset_b) - 50'(s2_y_r);

  always_comb begin
    if (&sum[49:31] || ~|sum[49:31]) begin
      u_sat = sum[31:0];
    end else if (sum[49]) begin
      u_sat = 32'sh8000_0000;
    end else begin
      u_sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (ld1) s1_v_r <= in_ch.valid;
      if (ld2) s2_v_r <= s1_v_r;
      if (ld3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_x_r   <= in_ch.point_x;
      s1_y_r   <= in_ch.point_y;
      s1_fin_r <= in_ch.final_point;
    end
    if (ld2) begin
      s2_prod_r <= prod;
      s2_y_r    <= s1_y_r;
      s2_fin_r  <= s1_fin_r;
    end
    if (ld3) begin
      s3_r.u   <= u_sat;
      s3_r.fin <= s2_fin_r;
    end
  end

  assign res_valid = s3_v_r;
  assign res       = s3_r;

endmodule

FILE: rtl/lirs_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_track: run tracker
// Classifies each residual against the limit, follows inlier runs, keeps the
// residual window, merges or displaces the held segment and forms results.
// ----------------------------------------------------------------------------
module lirs_track (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  lirs_pkg::resid_t      res,
  input  logic                  room,
  input  logic [30:0]           near_limit,
  output logic                  take,
  output lirs_pkg::push_t       push
);

  localparam int PT_W  = lirs_pkg::PT_W;
  localparam int SEG_W = lirs_pkg::SEG_W;

  lirs_pkg::phase_t   phase_r, phase_nxt;
  logic [PT_W-1:0]    idx_r, idx_nxt, run_start_r, run_start_nxt;
  logic signed [31:0] wmin_r, wmin_nxt, wmax_r, wmax_nxt;
  logic signed [31:0] anchor_r, anchor_nxt, prev_r, prev_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic [PT_W-1:0]    held_start_r, held_start_nxt, held_end_r, held_end_nxt;
  logic [SEG_W-1:0]   count_r, count_nxt;

  logic signed [31:0] u;
  logic               fresh, in_run, over, under;
  logic [31:0]        mag;
  logic signed [31:0] wmin_cur, wmax_cur, anchor_cur, srch_min, srch_max;
  logic [PT_W-1:0]    end_before;

  logic               fin_do;
  logic [PT_W-1:0]    fin_s0, fin_s1;
  logic signed [31:0] fin_wmin, fin_wmax, fin_prev;
  logic signed [32:0] spread;
  logic signed [PT_W:0] gap, run_len, held_len;
  logic               longs, merge, emit_held, place;

  logic               hv_a;
  logic [PT_W-1:0]    hs_a, he_a;
  logic signed [31:0] anchor_a;
  logic [SEG_W-1:0]   count_a;

  assign take = res_valid && room;
  assign u    = res.u;

  assign fresh  = (phase_r == lirs_pkg::PH_FRESH);
  assign in_run = (phase_r == lirs_pkg::PH_RUN);

  assign mag   = u[31] ? (~u + 32'd1) : u;
  assign over  = mag > {1'b0, near_limit};
  assign under = mag < {1'b0, near_limit};

  assign wmin_cur   = fresh ? u : wmin_r;
  assign wmax_cur   = fresh ? u : wmax_r;
  assign anchor_cur = fresh ? u : anchor_r;
  assign srch_min   = (u < wmin_cur) ? u : wmin_cur;
  assign srch_max   = (u > wmax_cur) ? u : wmax_cur;
  assign end_before = (idx_r > run_start_r) ? idx_r - PT_W'(1) : run_start_r;

  // a run closes on an outlier or at end of stream
  assign fin_do   = in_run ? (over || res.fin) : (under && res.fin);
  assign fin_s0   = in_run ? run_start_r : idx_r;
  assign fin_s1   = (in_run && over) ? end_before : idx_r;
  assign fin_wmin = in_run ? wmin_r : srch_min;
  assign fin_wmax = in_run ? wmax_r : srch_max;
  assign fin_prev = (in_run && over) ? prev_r : u;

  assign spread   = 33'(fin_wmax) - 33'(fin_wmin);
  assign gap      = $signed({1'b0, fin_s0}) - $signed({1'b0, held_end_r});
  assign run_len  = $signed({1'b0, fin_s1}) - $signed({1'b0, fin_s0});
  assign held_len = $signed({1'b0, held_end_r}) - $signed({1'b0, held_start_r});

  assign longs = (run_len > lirs_pkg::MIN_LEN) && (held_len > lirs_pkg::MIN_LEN);
  assign merge = held_valid_r && longs &&
                 ((spread < lirs_pkg::SPREAD_TIGHT) ||
                  ((gap <= lirs_pkg::MAX_GAP) && (spread < lirs_pkg::SPREAD_LOOSE)));
  assign emit_held = fin_do && held_valid_r && !merge;
  assign place     = fin_do && !merge;

  // held segment after this point's run is placed
  assign hv_a     = held_valid_r || fin_do;
  assign hs_a     = place ? fin_s0 : held_start_r;
  assign he_a     = fin_do ? fin_s1 : held_end_r;
  assign anchor_a = place ? fin_prev : anchor_cur;
  assign count_a  = count_r + SEG_W'(emit_held);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (res.fin) begin
        phase_nxt = lirs_pkg::PH_FRESH;
      end else if (in_run) begin
        phase_nxt = over ? lirs_pkg::PH_SEARCH : lirs_pkg::PH_RUN;
      end else begin
        phase_nxt = under ? lirs_pkg::PH_RUN : lirs_pkg::PH_SEARCH;
      end
    end
  end

  // datapath updates and results
  always_comb begin
    idx_nxt        = idx_r;
    run_start_nxt  = run_start_r;
    wmin_nxt       = wmin_r;
    wmax_nxt       = wmax_r;
    anchor_nxt     = anchor_r;
    prev_nxt       = prev_r;
    held_valid_nxt = held_valid_r;
    held_start_nxt = held_start_r;
    held_end_nxt   = held_end_r;
    count_nxt      = count_r;

    push.v0           = take && emit_held;
    push.s0.seg_valid = 1'b1;
    push.s0.seg_index = count_r;
    push.s0.seg_start = lirs_pkg::to_seg_idx(held_start_r);
    push.s0.seg_end   = lirs_pkg::to_seg_idx(held_end_r);
    push.s0.seg_last  = 1'b0;

    push.v1           = take && res.fin;
    push.s1.seg_valid = hv_a;
    push.s1.seg_index = count_a;
    push.s1.seg_start = hv_a ? lirs_pkg::to_seg_idx(hs_a) : '0;
    push.s1.seg_end   = hv_a ? lirs_pkg::to_seg_idx(he_a) : '0;
    push.s1.seg_last  = 1'b1;

    if (take) begin
      if (res.fin) begin
        idx_nxt        = '0;
        run_start_nxt  = '0;
        wmin_nxt       = '0;
        wmax_nxt       = '0;
        anchor_nxt     = '0;
        prev_nxt       = '0;
        held_valid_nxt = 1'b0;
        held_start_nxt = '0;
        held_end_nxt   = '0;
        count_nxt      = '0;
      end else begin
        idx_nxt        = (idx_r < lirs_pkg::PT_LAST) ? idx_r + PT_W'(1) : idx_r;
        anchor_nxt     = anchor_a;
        held_valid_nxt = hv_a;
        held_start_nxt = hs_a;
        held_end_nxt   = he_a;
        count_nxt      = count_a;
        if (in_run) begin
          if (over) begin
            // reopen the window at the anchor
            wmin_nxt = anchor_a;
            wmax_nxt = anchor_a;
          end else begin
            prev_nxt = u;
          end
        end else begin
          wmin_nxt = srch_min;
          wmax_nxt = srch_max;
          if (under) begin
            run_start_nxt = idx_r;
            prev_nxt      = u;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lirs_pkg::PH_FRESH;
      idx_r        <= '0;
      run_start_r  <= '0;
      wmin_r       <= '0;
      wmax_r       <= '0;
      anchor_r     <= '0;
      prev_r       <= '0;
      held_valid_r <= 1'b0;
      held_start_r <= '0;
      held_end_r   <= '0;
      count_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      run_start_r  <= run_start_nxt;
      wmin_r       <= wmin_nxt;
      wmax_r       <= wmax_nxt;
      anchor_r     <= anchor_nxt;
      prev_r       <= prev_nxt;
      held_valid_r <= held_valid_nxt;
      held_start_r <= held_start_nxt;
      held_end_r   <= held_end_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

FILE: rtl/lirs_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_outq: result queue
// Small FIFO that takes up to two results a cycle, hands out one when ready.
// ----------------------------------------------------------------------------
module lirs_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  lirs_pkg::push_t push,
  output logic            room,
  lirs_out_if.source      out_ch
);

  localparam int Q_AW = lirs_pkg::Q_AW;
  localparam int Q_CW = lirs_pkg::Q_CW;

  lirs_pkg::seg_t  q_mem [lirs_pkg::Q_DEPTH];
  lirs_pkg::seg_t  head;
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_second;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic [1:0]      n_push;
  logic            pop;

  assign room   = count_r <= Q_CW'(lirs_pkg::Q_DEPTH - 2);
  assign pop    = out_ch.valid && out_ch.ready;
  assign n_push = {1'b0, push.v0} + {1'b0, push.v1};

  assign wp_second = push.v0 ? wp_r + Q_AW'(1) : wp_r;
  assign wp_nxt    = wp_r + Q_AW'(n_push);
  assign rp_nxt    = pop ? rp_r + Q_AW'(1) : rp_r;
  assign count_nxt = count_r + Q_CW'(n_push) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) q_mem[wp_r] <= push.s0;
    if (push.v1) q_mem[wp_second] <= push.s1;
  end

  assign head             = q_mem[rp_r];
  assign out_ch.valid     = count_r != '0;
  assign out_ch.seg_valid = head.seg_valid;
  assign out_ch.seg_index = head.seg_index;
  assign out_ch.seg_start = head.seg_start;
  assign out_ch.seg_end   = head.seg_end;
  assign out_ch.seg_last  = head.seg_last;

endmodule

FILE: rtl/line_inlier_run_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_inlier_run_segmenter_unit: inlier run segmenter against a fixed line
// Computes each point's residual to the configured line, finds runs of
// inliers and emits merged segments as start/end point indices.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the input is not stalled. A
// transferred point passes the input register and the product register (one
// 32x32 product) and then reaches the residual register (add and saturate);
// the run tracker classifies it while it sits there, and its results (none,
// one or two) are written to a four-entry queue on the edge at which the
// tracker takes it. The input stalls only while the queue cannot take two
// more results, i.e. while it holds more than two results that the output
// side has not taken yet, and the residual pipe behind the tracker is full.
// Write the configuration registers only while no point is in flight.
module line_inlier_run_segmenter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  lirs_in_if.sink                        in_ch,
  lirs_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lirs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic signed [31:0] slope_r, offset_r;
  logic [30:0]        limit_r;
  logic               res_valid, take, room;
  lirs_pkg::resid_t   res;
  lirs_pkg::push_t    push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= '0;
      offset_r <= '0;
      limit_r  <= lirs_pkg::NEAR_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lirs_pkg::CFG_SLOPE_A:  slope_r  <= cfg_data;
        lirs_pkg::CFG_OFFSET_B: offset_r <= cfg_data;
        lirs_pkg::CFG_NEAR_LIM: limit_r  <= cfg_data[30:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  lirs_resid u_resid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .slope_a   (slope_r),
    .offset_b  (offset_r),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  lirs_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .room       (room),
    .near_limit (limit_r),
    .take       (take),
    .push       (push)
  );

  lirs_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
